>>> sv/tcw_pkg.sv
// Shared constants and types of the text console writer.
`timescale 1ns / 1ps

package tcw_pkg;

  // Default screen geometry.
  localparam int unsigned ColumnsDef = 80;
  localparam int unsigned RowsDef    = 25;

  // Fixed field widths of the channel words.
  localparam int unsigned ModeW     = 1;
  localparam int unsigned CharW     = 8;
  localparam int unsigned RowFldW   = 5;
  localparam int unsigned ColFldW   = 7;
  localparam int unsigned CellW     = 16;
  localparam int unsigned ColorW    = 8;

  // Character codes and reset values.
  localparam logic [CharW-1:0]  NewlineCode = 8'd10;
  localparam logic [CharW-1:0]  SpaceCode   = 8'd32;
  localparam logic [ColorW-1:0] ColorReset  = 8'd10;
  localparam logic [CellW-1:0]  CellReset   = {ColorReset, SpaceCode};

  // Item modes.
  localparam logic [ModeW-1:0] ModeWrite = 1'b0;
  localparam logic [ModeW-1:0] ModeRead  = 1'b1;

  // Status from the memory sweep engine to the front end.
  typedef struct packed {
    logic run;     // memory free for item traffic
    logic scroll;  // row copy or last-row clear in progress
  } tcw_sweep_stat_t;

endpackage

>>> sv/tcw_in_if.sv
// Input channel: one write or read request word.
`timescale 1ns / 1ps

interface tcw_in_if
  import tcw_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [ModeW-1:0]   mode;
  logic [CharW-1:0]   char_code;
  logic [RowFldW-1:0] read_row;
  logic [ColFldW-1:0] read_column;

  modport source (output valid, output mode, output char_code, output read_row,
                  output read_column, input ready);
  modport sink   (input valid, input mode, input char_code, input read_row,
                  input read_column, output ready);
endinterface

>>> sv/tcw_out_if.sv
// Output channel: one result word per accepted request.
`timescale 1ns / 1ps

interface tcw_out_if
  import tcw_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [CellW-1:0]   cell_data;
  logic [RowFldW-1:0] cursor_row;
  logic [ColFldW-1:0] cursor_column;
  logic               scrolled;

  modport source (output valid, output cell_data, output cursor_row,
                  output cursor_column, output scrolled, input ready);
  modport sink   (input valid, input cell_data, input cursor_row,
                  input cursor_column, input scrolled, output ready);
endinterface

>>> sv/tcw_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module tcw_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 2000,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/tcw_sweep.sv
// Memory sweep engine: reset clear, scroll copy, last-row clear, port mux.
`timescale 1ns / 1ps

module tcw_sweep
  import tcw_pkg::*;
#(
  parameter int unsigned COLUMNS = ColumnsDef,
  parameter int unsigned ROWS    = RowsDef,
  localparam int unsigned CellCount = ROWS * COLUMNS,
  localparam int unsigned LastBase  = (ROWS - 1) * COLUMNS,
  localparam int unsigned AddrW     = $clog2(CellCount)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             scroll_start_i,
  input  logic [ColorW-1:0] color_i,
  input  logic             fe_we_i,
  input  logic [AddrW-1:0] fe_waddr_i,
  input  logic [CellW-1:0] fe_wdata_i,
  input  logic             fe_re_i,
  input  logic [AddrW-1:0] fe_raddr_i,
  input  logic [CellW-1:0] ram_rdata_i,
  output logic             ram_we_o,
  output logic [AddrW-1:0] ram_waddr_o,
  output logic [CellW-1:0] ram_wdata_o,
  output logic             ram_re_o,
  output logic [AddrW-1:0] ram_raddr_o,
  output tcw_sweep_stat_t  stat_o
);

  typedef enum logic [3:0] {
    StInit  = 4'b0001,
    StRun   = 4'b0010,
    StCopy  = 4'b0100,
    StClear = 4'b1000
  } tcw_sweep_state_e;

  tcw_sweep_state_e state_q, state_d;
  logic [AddrW-1:0] cnt_q, cnt_d;
  logic             cp_pend_q, cp_pend_d;
  logic [AddrW-1:0] cp_addr_q, cp_addr_d;

  localparam logic [AddrW-1:0] LastCell = AddrW'(CellCount - 1);
  localparam logic [AddrW-1:0] LastBaseA = AddrW'(LastBase);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cp_pend_d   = 1'b0;
    cp_addr_d   = cp_addr_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = cnt_q;
    ram_wdata_o = CellReset;
    ram_re_o    = 1'b0;
    ram_raddr_o = fe_raddr_i;
    case (state_q)
      StInit: begin
        ram_we_o = 1'b1;
        if (cnt_q == LastCell) begin
          state_d = StRun;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      StRun: begin
        ram_we_o    = fe_we_i;
        ram_waddr_o = fe_waddr_i;
        ram_wdata_o = fe_wdata_i;
        ram_re_o    = fe_re_i;
        if (scroll_start_i) begin
          state_d = StCopy;
          cnt_d   = '0;
        end
      end
      StCopy: begin
        // Write back the row below in the cycle after its read.
        ram_we_o    = cp_pend_q;
        ram_waddr_o = cp_addr_q;
        ram_wdata_o = ram_rdata_i;
        if (cnt_q != LastBaseA) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = cnt_q + AddrW'(COLUMNS);
          cp_pend_d   = 1'b1;
          cp_addr_d   = cnt_q;
          cnt_d       = cnt_q + 1'b1;
        end else begin
          state_d = StClear;
        end
      end
      StClear: begin
        ram_we_o    = 1'b1;
        ram_wdata_o = {color_i, SpaceCode};
        if (cnt_q == LastCell) begin
          state_d = StRun;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: begin
        state_d = StInit;
        cnt_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StInit;
      cnt_q     <= '0;
      cp_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      cp_pend_q <= cp_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cp_addr_q <= cp_addr_d;
  end

  assign stat_o.run    = (state_q == StRun);
  assign stat_o.scroll = (state_q == StCopy) || (state_q == StClear);

  a_start_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scroll_start_i |-> state_q == StRun)
    else $error("scroll started outside run state");

  a_copy_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StCopy && ram_we_o && ram_re_o) |-> ram_waddr_o != ram_raddr_o)
    else $error("copy read and write hit the same cell");

  a_clear_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StClear) |-> !cp_pend_q)
    else $error("copy write still pending during row clear");

endmodule

>>> sv/text_console_writer_top.sv
// Top level of the text console writer: cursor, handshake stages, screen RAM.
//
//   channel  dir   handshake        word
//   in_if    in    valid / ready    mode, char_code, read_row, read_column
//   out_if   out   valid / ready    cell_data, cursor_row, cursor_column, scrolled
//   cfg      in    cfg_we_i         cfg_data_i -> text_color
//
// A new read or plain character write can be taken while the one before it
// leaves the read stage; each result word passes the registered read of the
// screen RAM and then the result register, which captures it unless stalled.
// A scroll holds input while each row below the first is copied up one, cell
// by cell through the RAM's read and write ports, and the last row is then
// cleared. After reset a clearing pass over all ROWS*COLUMNS cells fills
// the screen with light green spaces; no request is taken until it ends.
// A stalled result stage holds the next request in the RAM read stage.
`timescale 1ns / 1ps

module text_console_writer_top
  import tcw_pkg::*;
#(
  parameter int unsigned COLUMNS = ColumnsDef,
  parameter int unsigned ROWS    = RowsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [ColorW-1:0] cfg_data_i,
  tcw_in_if.sink            in_if,
  tcw_out_if.source         out_if
);

  localparam int unsigned CellCount = ROWS * COLUMNS;
  localparam int unsigned AddrW     = $clog2(CellCount);
  localparam int unsigned RowW      = $clog2(ROWS);
  localparam int unsigned ColW      = $clog2(COLUMNS);
  localparam int unsigned RdW       = RowFldW + ColFldW + $clog2(COLUMNS + 1);

  // Request stage waiting for RAM data.
  typedef struct packed {
    logic            use_ram;
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic            scrolled;
  } tcw_pend_t;

  logic [ColorW-1:0] color_q;

  // Cursor: row, column, row base address and linear cell address.
  logic [RowW-1:0]  row_q, row_d;
  logic [ColW-1:0]  col_q, col_d;
  logic [AddrW-1:0] base_q, base_d;
  logic [AddrW-1:0] caddr_q, caddr_d;

  logic      p1_valid_q, p1_valid_d;
  tcw_pend_t p1_q, p1_d;
  logic      p1_move;

  logic               out_valid_q, out_valid_d;
  logic [CellW-1:0]   out_data_q;
  logic [RowFldW-1:0] out_row_q;
  logic [ColFldW-1:0] out_col_q;
  logic               out_scr_q;

  logic in_fire;
  logic next_line;
  logic at_last_row;
  logic scroll_start;
  logic is_char;

  logic [RdW-1:0]   rd_lin;
  logic             rd_in_bounds;

  logic             fe_we;
  logic [CellW-1:0] fe_wdata;
  logic             fe_re;

  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [CellW-1:0] ram_wdata;
  logic             ram_re;
  logic [AddrW-1:0] ram_raddr;
  logic [CellW-1:0] ram_rdata;

  tcw_sweep_stat_t sweep_stat;

  // Take a request only while the RAM is free and the read stage drains.
  assign p1_move     = p1_valid_q && (!out_valid_q || out_if.ready);
  assign in_if.ready = sweep_stat.run && (!p1_valid_q || p1_move);
  assign in_fire     = in_if.valid && in_if.ready;

  // Read address: one small multiply, bounds checked on the raw fields.
  assign rd_lin = RdW'(in_if.read_row) * RdW'(COLUMNS) + RdW'(in_if.read_column);
  assign rd_in_bounds = (RdW'(in_if.read_row) < RdW'(ROWS)) &&
                        (RdW'(in_if.read_column) < RdW'(COLUMNS));

  assign is_char     = (in_if.mode == ModeWrite) && (in_if.char_code != NewlineCode);
  assign at_last_row = (row_q == RowW'(ROWS - 1));
  // Newline, or a character in the last column, moves to the next row.
  assign next_line   = (in_if.mode == ModeWrite) &&
                       (!is_char || (col_q == ColW'(COLUMNS - 1)));
  assign scroll_start = in_fire && next_line && at_last_row;

  assign fe_we    = in_fire && is_char;
  assign fe_wdata = {color_q, in_if.char_code};
  assign fe_re    = in_fire && (in_if.mode == ModeRead) && rd_in_bounds;

  // Advance the cursor.
  always_comb begin
    row_d   = row_q;
    col_d   = col_q;
    base_d  = base_q;
    caddr_d = caddr_q;
    if (in_fire && in_if.mode == ModeWrite) begin
      if (next_line) begin
        col_d = '0;
        if (at_last_row) begin
          // Scroll: cursor stays on the last row.
          caddr_d = base_q;
        end else begin
          row_d   = row_q + 1'b1;
          base_d  = base_q + AddrW'(COLUMNS);
          caddr_d = base_q + AddrW'(COLUMNS);
        end
      end else begin
        col_d   = col_q + 1'b1;
        caddr_d = caddr_q + 1'b1;
      end
    end
  end

  // Read stage and result register.
  always_comb begin
    p1_valid_d = p1_valid_q;
    if (in_fire) begin
      p1_valid_d = 1'b1;
    end else if (p1_move) begin
      p1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (p1_move) begin
      out_valid_d = 1'b1;
    end else if (out_if.ready) begin
      out_valid_d = 1'b0;
    end
    p1_d          = p1_q;
    if (in_fire) begin
      p1_d.use_ram  = fe_re;
      p1_d.row      = row_d;
      p1_d.col      = col_d;
      p1_d.scrolled = scroll_start;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q     <= ColorReset;
      row_q       <= '0;
      col_q       <= '0;
      base_q      <= '0;
      caddr_q     <= '0;
      p1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        color_q <= cfg_data_i;
      end
      row_q       <= row_d;
      col_q       <= col_d;
      base_q      <= base_d;
      caddr_q     <= caddr_d;
      p1_valid_q  <= p1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk_i) begin
    p1_q <= p1_d;
    if (p1_move) begin
      out_data_q <= p1_q.use_ram ? ram_rdata : '0;
      out_row_q  <= RowFldW'(p1_q.row);
      out_col_q  <= ColFldW'(p1_q.col);
      out_scr_q  <= p1_q.scrolled;
    end
  end

  assign out_if.valid         = out_valid_q;
  assign out_if.cell_data     = out_data_q;
  assign out_if.cursor_row    = out_row_q;
  assign out_if.cursor_column = out_col_q;
  assign out_if.scrolled      = out_scr_q;

  tcw_sweep #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_sweep (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .scroll_start_i (scroll_start),
    .color_i        (color_q),
    .fe_we_i        (fe_we),
    .fe_waddr_i     (caddr_q),
    .fe_wdata_i     (fe_wdata),
    .fe_re_i        (fe_re),
    .fe_raddr_i     (AddrW'(rd_lin)),
    .ram_rdata_i    (ram_rdata),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .ram_re_o       (ram_re),
    .ram_raddr_o    (ram_raddr),
    .stat_o         (sweep_stat)
  );

  tcw_ram #(
    .Width (CellW),
    .Depth (CellCount)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  a_no_fire_in_scroll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sweep_stat.scroll |-> !in_fire)
    else $error("request taken during scroll");

  a_read_data_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p1_valid_q && p1_q.use_ram && !p1_move) |-> !ram_re)
    else $error("RAM read issued while a read result is waiting");

  a_scroll_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scroll_start |=> (row_q == RowW'(ROWS - 1)) && (col_q == '0) && sweep_stat.scroll)
    else $error("scroll left cursor off the last row start");

endmodule
